[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked property on the rising clock edge, quiet while reset is held
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked property on the rising clock edge, also during reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/iaie_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package iaie_pkg;

  // array sizing
  localparam int CAPACITY = 256;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // beat field widths
  localparam int REQ_W = 3;
  localparam int POS_W = 9;
  localparam int VAL_W = 32;
  localparam int LEN_W = 9;
  localparam int RD_W  = 32;
  localparam int ERR_W = 2;

  // common width for index, length and position compares
  localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

  // request codes
  localparam logic [REQ_W-1:0] REQ_INSERT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_ERASE  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_READ   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_WRITE  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_RESIZE = 3'd4;
  localparam logic [REQ_W-1:0] REQ_PUSH   = 3'd5;
  localparam logic [REQ_W-1:0] REQ_POP    = 3'd6;

  // error codes
  localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_RANGE = 2'd1;
  localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;

  // cell update operations broadcast along the row
  localparam logic [2:0] OP_NONE   = 3'd0;
  localparam logic [2:0] OP_INSERT = 3'd1;
  localparam logic [2:0] OP_ERASE  = 3'd2;
  localparam logic [2:0] OP_WRITE  = 3'd3;
  localparam logic [2:0] OP_FILL   = 3'd4;

  typedef struct packed {
    logic [2:0]        op;
    logic [CMP_W-1:0]  pos;
    logic [CMP_W-1:0]  cnt;
    logic [CMP_W-1:0]  nlen;
    logic [DATA_W-1:0] value;
  } cmd_t;

  // read chain control
  typedef struct packed {
    logic load;
    logic shift;
  } rd_ctl_t;

endpackage

`default_nettype wire

[rtl/iaie_req_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface iaie_req_if;
  logic                        valid;
  logic                        ready;
  logic [iaie_pkg::REQ_W-1:0]  req_type;
  logic [iaie_pkg::POS_W-1:0]  position;
  logic [iaie_pkg::VAL_W-1:0]  value;
  logic [iaie_pkg::LEN_W-1:0]  new_length;

  modport source (output valid, req_type, position, value, new_length, input ready);
  modport sink (input valid, req_type, position, value, new_length, output ready);
endinterface

`default_nettype wire

[rtl/iaie_rsp_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface iaie_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [iaie_pkg::RD_W-1:0]   read_value;
  logic [iaie_pkg::LEN_W-1:0]  length;
  logic [iaie_pkg::ERR_W-1:0]  error_code;

  modport source (output valid, read_value, length, error_code, input ready);
  modport sink (input valid, read_value, length, error_code, output ready);
endinterface

`default_nettype wire

[rtl/iaie_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module iaie_cell (
  input  wire logic                           clk,
  input  wire logic [iaie_pkg::IDX_W-1:0]     idx,
  input  wire iaie_pkg::cmd_t                 cmd,
  input  wire iaie_pkg::rd_ctl_t              rctl,
  input  wire logic [iaie_pkg::DATA_W-1:0]    left,
  input  wire logic [iaie_pkg::DATA_W-1:0]    right,
  input  wire logic [iaie_pkg::DATA_W-1:0]    rd_in,
  output logic      [iaie_pkg::DATA_W-1:0]    word,
  output logic      [iaie_pkg::DATA_W-1:0]    rd
);

  logic [iaie_pkg::DATA_W-1:0] word_r, word_nxt;
  logic [iaie_pkg::DATA_W-1:0] rd_r, rd_nxt;
  logic [iaie_pkg::CMP_W-1:0]  idx_c;

  assign idx_c = iaie_pkg::CMP_W'(idx);

  // entry update: take a neighbor on shifts, the request word on a hit or in the fill range
  always_comb begin
    word_nxt = word_r;
    unique case (cmd.op)
      iaie_pkg::OP_INSERT: begin
        if (idx_c == cmd.pos) begin
          word_nxt = cmd.value;
        end else if (idx_c > cmd.pos) begin
          word_nxt = left;
        end
      end
      iaie_pkg::OP_ERASE: begin
        if (idx_c >= cmd.pos) begin
          word_nxt = right;
        end
      end
      iaie_pkg::OP_WRITE: begin
        if (idx_c == cmd.pos) begin
          word_nxt = cmd.value;
        end
      end
      iaie_pkg::OP_FILL: begin
        if (idx_c >= cmd.cnt && idx_c < cmd.nlen) begin
          word_nxt = cmd.value;
        end
      end
      default: begin
        word_nxt = word_r;
      end
    endcase
  end

  // read chain: selected cell loads its entry, then it moves toward cell 0
  always_comb begin
    rd_nxt = rd_r;
    if (rctl.load && idx_c == cmd.pos) begin
      rd_nxt = word_r;
    end else if (rctl.load || rctl.shift) begin
      rd_nxt = rd_in;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    rd_r   <= rd_nxt;
  end

  assign word = word_r;
  assign rd   = rd_r;

endmodule

`default_nettype wire

[rtl/iaie_array.sv]
`timescale 1ns / 1ps
`default_nettype none

module iaie_array (
  input  wire logic                         clk,
  input  wire iaie_pkg::cmd_t               cmd,
  input  wire iaie_pkg::rd_ctl_t            rctl,
  output logic      [iaie_pkg::DATA_W-1:0]  rd_out
);

  logic [iaie_pkg::DATA_W-1:0] words [iaie_pkg::CAPACITY];
  logic [iaie_pkg::DATA_W-1:0] rds   [iaie_pkg::CAPACITY];

  // row of cells, inner ones linked to both neighbors
  for (genvar i = 0; i < iaie_pkg::CAPACITY; i++) begin : g_cell
    logic [iaie_pkg::DATA_W-1:0] left_w, right_w, rd_in_w;

    if (i == 0) begin : g_first
      assign left_w = cmd.value;
    end else begin : g_mid_l
      assign left_w = words[i-1];
    end

    if (i == iaie_pkg::CAPACITY - 1) begin : g_last
      assign right_w = words[i];
      assign rd_in_w = '0;
    end else begin : g_mid_r
      assign right_w = words[i+1];
      assign rd_in_w = rds[i+1];
    end

    iaie_cell u_cell (
      .clk   (clk),
      .idx   (iaie_pkg::IDX_W'(i)),
      .cmd   (cmd),
      .rctl  (rctl),
      .left  (left_w),
      .right (right_w),
      .rd_in (rd_in_w),
      .word  (words[i]),
      .rd    (rds[i])
    );
  end

  assign rd_out = rds[0];

endmodule

`default_nettype wire

[rtl/indexed_array_insert_erase_top.sv]
// each accepted request gets a registered response beat; a successful read
//   first moves its entry down the read chain to cell 0
// throughput: one request per cycle for all but reads, while the response
//   slot is free; reads hold the input as the entry moves one cell per cycle
// reset: clears the length and the control state; stored words are not cleared
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module indexed_array_insert_erase_top (
  input  wire logic  clk,
  input  wire logic  rst_n,
  iaie_req_if.sink   in_ch,
  iaie_rsp_if.source out_ch
);

  localparam logic [0:0] S_IDLE  = 1'b0;
  localparam logic [0:0] S_SHIFT = 1'b1;

  logic [0:0]                     state_r, state_nxt;
  logic [iaie_pkg::CNT_W-1:0]     count_r, count_nxt;
  logic [iaie_pkg::IDX_W-1:0]     cnt_r, cnt_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [iaie_pkg::RD_W-1:0]      out_rd_r, out_rd_nxt;
  logic [iaie_pkg::LEN_W-1:0]     out_len_r, out_len_nxt;
  logic [iaie_pkg::ERR_W-1:0]     out_err_r, out_err_nxt;

  logic                           in_acc;
  logic                           slot_free;
  logic                           read_ok;
  logic [iaie_pkg::ERR_W-1:0]     err_c;
  logic [iaie_pkg::CNT_W-1:0]     len_c;
  logic [iaie_pkg::CMP_W-1:0]     pos_c, cnt_c, nlen_c, cap_c;
  logic [iaie_pkg::DATA_W-1:0]    rd_word;
  iaie_pkg::cmd_t                 cmd;
  iaie_pkg::rd_ctl_t              rctl;

  assign slot_free   = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && slot_free;
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign pos_c  = iaie_pkg::CMP_W'(in_ch.position);
  assign cnt_c  = iaie_pkg::CMP_W'(count_r);
  assign nlen_c = iaie_pkg::CMP_W'(in_ch.new_length);
  assign cap_c  = iaie_pkg::CMP_W'(iaie_pkg::CAPACITY);

  // request decode: error check, new length and the cell operation
  always_comb begin
    cmd.op    = iaie_pkg::OP_NONE;
    cmd.pos   = pos_c;
    cmd.cnt   = cnt_c;
    cmd.nlen  = nlen_c;
    cmd.value = iaie_pkg::DATA_W'(in_ch.value);
    err_c     = iaie_pkg::ERR_OK;
    len_c     = count_r;
    read_ok   = 1'b0;
    unique case (in_ch.req_type)
      iaie_pkg::REQ_INSERT: begin
        if (pos_c > cnt_c) begin
          err_c = iaie_pkg::ERR_RANGE;
        end else if (cnt_c == cap_c) begin
          err_c = iaie_pkg::ERR_FULL;
        end else begin
          cmd.op = iaie_pkg::OP_INSERT;
          len_c  = iaie_pkg::CNT_W'(count_r + 1'b1);
        end
      end
      iaie_pkg::REQ_PUSH: begin
        cmd.pos = cnt_c;
        if (cnt_c == cap_c) begin
          err_c = iaie_pkg::ERR_FULL;
        end else begin
          cmd.op = iaie_pkg::OP_INSERT;
          len_c  = iaie_pkg::CNT_W'(count_r + 1'b1);
        end
      end
      iaie_pkg::REQ_ERASE: begin
        if (pos_c >= cnt_c) begin
          err_c = iaie_pkg::ERR_RANGE;
        end else begin
          cmd.op = iaie_pkg::OP_ERASE;
          len_c  = iaie_pkg::CNT_W'(count_r - 1'b1);
        end
      end
      iaie_pkg::REQ_READ: begin
        if (pos_c >= cnt_c) begin
          err_c = iaie_pkg::ERR_RANGE;
        end else begin
          read_ok = 1'b1;
        end
      end
      iaie_pkg::REQ_WRITE: begin
        if (pos_c >= cnt_c) begin
          err_c = iaie_pkg::ERR_RANGE;
        end else begin
          cmd.op = iaie_pkg::OP_WRITE;
        end
      end
      iaie_pkg::REQ_RESIZE: begin
        if (nlen_c > cap_c) begin
          err_c = iaie_pkg::ERR_FULL;
        end else begin
          cmd.op = iaie_pkg::OP_FILL;
          len_c  = iaie_pkg::CNT_W'(nlen_c);
        end
      end
      iaie_pkg::REQ_POP: begin
        if (count_r == '0) begin
          err_c = iaie_pkg::ERR_RANGE;
        end else begin
          len_c = iaie_pkg::CNT_W'(count_r - 1'b1);
        end
      end
      default: begin
        err_c = iaie_pkg::ERR_RANGE;
      end
    endcase
    if (!in_acc) begin
      cmd.op = iaie_pkg::OP_NONE;
    end
  end

  // read chain control
  assign rctl.load  = in_acc && read_ok;
  assign rctl.shift = (state_r == S_SHIFT) && (cnt_r != '0);

  iaie_array u_array (
    .clk    (clk),
    .cmd    (cmd),
    .rctl   (rctl),
    .rd_out (rd_word)
  );

  // sequencer and response register
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_rd_nxt    = out_rd_r;
    out_len_nxt   = out_len_r;
    out_err_nxt   = out_err_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          count_nxt = len_c;
          if (read_ok) begin
            state_nxt = S_SHIFT;
            cnt_nxt   = iaie_pkg::IDX_W'(pos_c);
          end else begin
            out_valid_nxt = 1'b1;
            out_rd_nxt    = '0;
            out_len_nxt   = iaie_pkg::LEN_W'(len_c);
            out_err_nxt   = err_c;
          end
        end
      end
      S_SHIFT: begin
        if (cnt_r != '0) begin
          cnt_nxt = cnt_r - 1'b1;
        end else if (slot_free) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_rd_nxt    = iaie_pkg::RD_W'(rd_word);
          out_len_nxt   = iaie_pkg::LEN_W'(count_r);
          out_err_nxt   = iaie_pkg::ERR_OK;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // response payload
  always_ff @(posedge clk) begin
    out_rd_r  <= out_rd_nxt;
    out_len_r <= out_len_nxt;
    out_err_r <= out_err_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_value = out_rd_r;
  assign out_ch.length     = out_len_r;
  assign out_ch.error_code = out_err_r;

  // checks
  `ASSERT_CLK(a_count_bound, count_r <= iaie_pkg::CNT_W'(iaie_pkg::CAPACITY), "length above capacity")
  `ASSERT_CLK(a_count_hold, !(in_ch.valid && in_ch.ready) |=> $stable(count_r), "length moved without a request beat")
  `ASSERT_CLK(a_chain_step, (state_r == S_SHIFT) && (cnt_r != '0) |=> (state_r == S_SHIFT) && (cnt_r == $past(cnt_r) - 1'b1), "read chain step lost")

endmodule

`default_nettype wire
